### sv/lewb_pkg.sv
// ----------------------------------------------------------------------------
// Loop-erased walk builder package
// Field widths, result codes and stream layout shared by the builder and its
// port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lewb_pkg;

    // Payload field widths.
    localparam int DIR_W   = 2;
    localparam int LEN_W   = 7;
    localparam int IDX_W   = 6;
    localparam int EV_W    = 2;
    localparam int COORD_W = 8;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Result kind, carried in tuser.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_STEP   = 1'b1;

    // What the latest step did to the path.
    localparam logic [EV_W-1:0] EV_APPEND = 2'd0;
    localparam logic [EV_W-1:0] EV_ERASE  = 2'd1;
    localparam logic [EV_W-1:0] EV_ORIGIN = 2'd2;

endpackage

`default_nettype wire

### sv/loop_erased_walk_builder_top.sv
// ----------------------------------------------------------------------------
// Loop-erased walk builder
// Builds a loop-erased lattice walk from a stream of step directions and
// emits the finished walk once it reaches the programmed length.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------
// s_axis    in   tdata[1:0] direction
// m_axis    out  tdata walk_length/erase_event/step_index/step_direction,
//                tuser kind, tlast last
// cfg       in   cfg_wr_data target_length, written when cfg_wr_en is high
//
// One step is taken at a time. For a step onto a path of P steps, the
// position RAM is scanned one entry per cycle with a single shared
// comparator, and entry zero (the origin) is checked as the step is
// accepted, so a step onto an empty path or back onto the origin skips the
// scan. A status beat then waits for the output side to take it, and only
// then is the next step taken. A finished walk is read out of the step RAM
// one beat at a time, each read waiting until the previous beat is taken.
// Reset clears the path to the origin and sets the target length to 64; the
// RAM contents need no clearing, as only entries written since the last
// clear are ever read. A stall on the output holds the beat and the block.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_erased_walk_builder_top #(
    parameter int MAX_STEPS = 64,
    parameter int DIMS      = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Slave stream: one lattice step per beat.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lewb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [1:0] direction
    // Master stream: status beats and finished-walk beats.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [6:0] walk_length, [8:7] erase_event, [14:9] step_index,
    // [16:15] step_direction, [23:17] zero
    output logic [lewb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] kind
    output logic                                m_axis_tlast,
    // Configuration: target_length.
    input  wire logic                           cfg_wr_en,
    input  wire logic [lewb_pkg::LEN_W-1:0]     cfg_wr_data
);

    localparam int PW = lewb_pkg::COORD_W * DIMS;
    localparam int AW = $clog2(MAX_STEPS);
    localparam logic [lewb_pkg::LEN_W-1:0] MAX_LEN = lewb_pkg::LEN_W'(MAX_STEPS);
    localparam logic [lewb_pkg::LEN_W-1:0] ONE_LEN = lewb_pkg::LEN_W'(1);
    localparam logic [lewb_pkg::LEN_W-1:0] TGT_RESET = lewb_pkg::LEN_W'(64);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_RESOLVE = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    // Moves one coordinate of a packed position by plus or minus one.
    // The axis is bit one of the direction, folded onto a single axis when
    // the lattice has only one dimension.
    function automatic logic [PW-1:0] move_head(input logic [PW-1:0] pos,
                                                input logic [1:0]    dir);
        logic [PW-1:0]                    res;
        logic [lewb_pkg::COORD_W-1:0]     c;
        int                               axis;
        res  = pos;
        axis = (DIMS > 1) ? int'(dir[1]) : 0;
        c    = pos[axis*lewb_pkg::COORD_W +: lewb_pkg::COORD_W];
        res[axis*lewb_pkg::COORD_W +: lewb_pkg::COORD_W] = dir[0] ? c - 1'b1 : c + 1'b1;
        return res;
    endfunction

    // Control state.
    logic [2:0]                    state_reg, state_next;
    logic [lewb_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [PW-1:0]                 head_reg, head_next;
    logic [lewb_pkg::LEN_W-1:0]    tgt_reg, tgt_next;
    logic                          out_vld_reg, out_vld_next;
    logic                          cmp_vld_reg, cmp_vld_next;

    // Per-item working registers.
    logic [PW-1:0]                 np_reg, np_next;
    logic [lewb_pkg::DIR_W-1:0]    dir_reg, dir_next;
    logic [lewb_pkg::LEN_W-1:0]    iss_reg, iss_next;
    logic [lewb_pkg::LEN_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                          hit_reg, hit_next;
    logic [lewb_pkg::LEN_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [lewb_pkg::EV_W-1:0]     ev_reg, ev_next;
    logic [lewb_pkg::LEN_W-1:0]    eidx_reg, eidx_next;
    logic                          out_kind_reg, out_kind_next;
    logic                          out_last_reg, out_last_next;
    logic [lewb_pkg::DIR_W-1:0]    out_dir_reg, out_dir_next;

    // RAM ports.
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [PW-1:0]                 pos_q;
    logic [lewb_pkg::DIR_W-1:0]    step_q;
    logic [lewb_pkg::LEN_W-1:0]    iss_m1;

    // Decode helpers.
    logic [PW-1:0]                 np_in;
    logic [lewb_pkg::LEN_W-1:0]    eff_tgt;
    logic [lewb_pkg::LEN_W-1:0]    new_len;
    logic [lewb_pkg::LEN_W-1:0]    eidx_p1;

    // Position entry k (k >= 1) lives at address k - 1; entry zero is the
    // origin and is never stored. The step RAM is indexed by step number.
    lewb_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_STEPS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (np_reg),
        .raddr (iss_m1[AW-1:0]),
        .rdata (pos_q)
    );

    lewb_ram #(
        .WIDTH (lewb_pkg::DIR_W),
        .DEPTH (MAX_STEPS)
    ) u_step_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (dir_reg),
        .raddr (eidx_reg[AW-1:0]),
        .rdata (step_q)
    );

    assign iss_m1  = iss_reg - ONE_LEN;
    assign wr_addr = len_reg[AW-1:0];
    assign np_in   = move_head(head_reg, s_axis_tdata[lewb_pkg::DIR_W-1:0]);
    assign eidx_p1 = eidx_reg + ONE_LEN;

    // A target of zero behaves as one; a target beyond the store is clamped.
    always_comb
    begin
        priority if (tgt_reg == '0)
        begin
            eff_tgt = ONE_LEN;
        end
        else if (tgt_reg > MAX_LEN)
        begin
            eff_tgt = MAX_LEN;
        end
        else
        begin
            eff_tgt = tgt_reg;
        end
    end

    // Path length after the step being resolved.
    always_comb
    begin
        priority if (hit_reg)
        begin
            new_len = hit_idx_reg;
        end
        else if (len_reg < MAX_LEN)
        begin
            new_len = len_reg + ONE_LEN;
        end
        else
        begin
            new_len = len_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {
        {(lewb_pkg::M_TDATA_W - 17){1'b0}},
        out_dir_reg,
        (out_kind_reg == lewb_pkg::KIND_STEP) ? eidx_reg[lewb_pkg::IDX_W-1:0]
                                              : {lewb_pkg::IDX_W{1'b0}},
        ev_reg,
        len_reg
    };

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        head_next     = head_reg;
        tgt_next      = cfg_wr_en ? cfg_wr_data : tgt_reg;
        out_vld_next  = out_vld_reg;
        cmp_vld_next  = cmp_vld_reg;
        np_next       = np_reg;
        dir_next      = dir_reg;
        iss_next      = iss_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        ev_next       = ev_reg;
        eidx_next     = eidx_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        out_dir_next  = out_dir_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    np_next      = np_in;
                    dir_next     = s_axis_tdata[lewb_pkg::DIR_W-1:0];
                    iss_next     = ONE_LEN;
                    cmp_vld_next = 1'b0;
                    hit_idx_next = '0;
                    // The origin is checked right away; an empty path has
                    // nothing else to scan.
                    if (np_in == '0)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_RESOLVE;
                    end
                    else if (len_reg == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_RESOLVE;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // One read issued and one compare done per cycle.
                if (cmp_vld_reg && (pos_q == np_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == len_reg))
                begin
                    hit_next     = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
                else if (iss_reg <= len_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg;
                    iss_next     = iss_reg + ONE_LEN;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end

            ST_RESOLVE:
            begin
                priority if (hit_reg && (hit_idx_reg == '0))
                begin
                    ev_next   = lewb_pkg::EV_ORIGIN;
                    head_next = '0;
                end
                else if (hit_reg)
                begin
                    // The matching entry is the new head by definition.
                    ev_next   = lewb_pkg::EV_ERASE;
                    head_next = np_reg;
                end
                else
                begin
                    ev_next = lewb_pkg::EV_APPEND;
                    if (len_reg < MAX_LEN)
                    begin
                        wr_en     = 1'b1;
                        head_next = np_reg;
                    end
                end
                len_next = new_len;

                if (new_len >= eff_tgt)
                begin
                    eidx_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = lewb_pkg::KIND_STATUS;
                    out_last_next = 1'b1;
                    out_dir_next  = '0;
                    state_next    = ST_OUT;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                out_vld_next  = 1'b1;
                out_kind_next = lewb_pkg::KIND_STEP;
                out_last_next = (eidx_p1 == len_reg);
                out_dir_next  = step_q;
                state_next    = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_vld_next = 1'b0;
                    if (out_last_reg)
                    begin
                        if (out_kind_reg == lewb_pkg::KIND_STEP)
                        begin
                            len_next  = '0;
                            head_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        eidx_next  = eidx_p1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            head_reg    <= '0;
            tgt_reg     <= TGT_RESET;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            head_reg    <= head_next;
            tgt_reg     <= tgt_next;
            out_vld_reg <= out_vld_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        np_reg       <= np_next;
        dir_reg      <= dir_next;
        iss_reg      <= iss_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        ev_reg       <= ev_next;
        eidx_reg     <= eidx_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_dir_reg  <= out_dir_next;
    end

endmodule

`default_nettype wire

### sv/lewb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lewb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/lewb_checker.sv
// ----------------------------------------------------------------------------
// Loop-erased walk builder port checker
// Watches the builder's ports and flags beats that break its contract.
// ----------------------------------------------------------------------------
`default_nettype none

module lewb_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lewb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    // The builder works on one step at a time: no new step while a result
    // is still on offer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // After taking a step the builder must go busy to search.
    a_busy_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready right after a step was taken");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result beat changed");

    // A status beat is alone in its run and carries no step.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lewb_pkg::KIND_STATUS)) |->
            (m_axis_tlast && (m_axis_tdata[16:9] == 8'd0)))
        else $error("malformed status beat");

    // A walk beat ends the run exactly at its final step.
    a_walk_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lewb_pkg::KIND_STEP)) |->
            (m_axis_tlast == (({1'b0, m_axis_tdata[14:9]} + 7'd1) == m_axis_tdata[6:0])))
        else $error("walk beat tlast does not match its step index");

endmodule

bind loop_erased_walk_builder_top lewb_checker u_lewb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Loop-erased walk builder testbench
// Drives lattice steps into the builder, tracks the loop-erased path with a
// scoreboard of its own, and compares every status and finished-walk beat
// field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STEPS = 64;
    localparam int DIMS      = 2;
    localparam int POS_W     = lewb_pkg::COORD_W * DIMS;

    // Direction codes: axis in bit 1, negative sense in bit 0.
    localparam logic [lewb_pkg::DIR_W-1:0] DIR_XPOS = 2'd0;
    localparam logic [lewb_pkg::DIR_W-1:0] DIR_XNEG = 2'd1;
    localparam logic [lewb_pkg::DIR_W-1:0] DIR_YPOS = 2'd2;
    localparam logic [lewb_pkg::DIR_W-1:0] DIR_YNEG = 2'd3;

    // One result beat as the scoreboard expects it.
    typedef struct {
        logic                        kind;
        logic [lewb_pkg::LEN_W-1:0]  walk_len;
        logic [lewb_pkg::EV_W-1:0]   ev;
        logic [lewb_pkg::IDX_W-1:0]  idx;
        logic [lewb_pkg::DIR_W-1:0]  step_dir;
        logic                        last;
    } walk_beat_t;

    // The scoreboard keeps its own copy of the loop-erased path: the step
    // codes, the positions visited (entry k is the position after k steps),
    // the head and the programmed target. Every accepted step is played on
    // this copy and the beats it causes are queued in order.
    class walk_scoreboard;
        logic [lewb_pkg::DIR_W-1:0] steps [MAX_STEPS];
        logic [POS_W-1:0] spots [MAX_STEPS+1];
        int unsigned      path_len;
        logic [POS_W-1:0] head;
        int unsigned      target;
        walk_beat_t       expected_beats [$];
        int unsigned      errors;
        int unsigned      steps_taken;
        int unsigned      beats_seen;
        int unsigned      walks_done;
        int unsigned      longest;
        int unsigned      erases;
        int unsigned      origin_hits;

        function new();
            for (int k = 0; k < MAX_STEPS; k++)
                steps[k] = '0;
            clear_path();
            target = 64;
        endfunction

        function void clear_path();
            for (int k = 0; k <= MAX_STEPS; k++)
                spots[k] = '0;
            path_len = 0;
            head = '0;
        endfunction

        // Coordinates wrap modulo 256; an axis beyond the lattice folds back.
        function logic [POS_W-1:0] moved(logic [POS_W-1:0] pos,
                                         logic [lewb_pkg::DIR_W-1:0] dir);
            int                           axis;
            logic [lewb_pkg::COORD_W-1:0] c;
            logic [POS_W-1:0]             r;
            axis = (int'(dir) >> 1) % DIMS;
            r = pos;
            c = pos[axis*lewb_pkg::COORD_W +: lewb_pkg::COORD_W];
            c = dir[0] ? c - 1'b1 : c + 1'b1;
            r[axis*lewb_pkg::COORD_W +: lewb_pkg::COORD_W] = c;
            return r;
        endfunction

        function int find_spot(logic [POS_W-1:0] pos);
            for (int k = 0; k <= int'(path_len) && k <= MAX_STEPS; k++)
                if (spots[k] == pos)
                    return k;
            return -1;
        endfunction

        function void take_step(logic [lewb_pkg::DIR_W-1:0] dir);
            logic [POS_W-1:0]          np;
            int                        hit;
            logic [lewb_pkg::EV_W-1:0] ev;
            int unsigned               eff;
            walk_beat_t                b;
            steps_taken++;
            np = moved(head, dir);
            hit = find_spot(np);
            if (hit < 0)
            begin
                if (path_len < MAX_STEPS)
                begin
                    steps[path_len] = dir;
                    path_len++;
                    spots[path_len] = np;
                    head = np;
                end
                ev = lewb_pkg::EV_APPEND;
            end
            else if (hit == 0)
            begin
                path_len = 0;
                head = '0;
                ev = lewb_pkg::EV_ORIGIN;
                origin_hits++;
            end
            else
            begin
                path_len = hit;
                head = spots[path_len];
                ev = lewb_pkg::EV_ERASE;
                erases++;
            end

            eff = (target == 0) ? 1 : ((target > MAX_STEPS) ? MAX_STEPS : target);

            if (path_len >= eff)
            begin
                for (int k = 0; k < int'(path_len); k++)
                begin
                    b.kind     = lewb_pkg::KIND_STEP;
                    b.walk_len = lewb_pkg::LEN_W'(path_len);
                    b.ev       = ev;
                    b.idx      = lewb_pkg::IDX_W'(k);
                    b.step_dir = steps[k];
                    b.last     = (k + 1 == int'(path_len));
                    expected_beats.insert(expected_beats.size(), b);
                end
                walks_done++;
                if (path_len > longest)
                    longest = path_len;
                clear_path();
            end
            else
            begin
                b.kind     = lewb_pkg::KIND_STATUS;
                b.walk_len = lewb_pkg::LEN_W'(path_len);
                b.ev       = ev;
                b.idx      = '0;
                b.step_dir = '0;
                b.last     = 1'b1;
                expected_beats.insert(expected_beats.size(), b);
            end
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [lewb_pkg::M_TDATA_W-1:0] data, logic user, logic tl);
            walk_beat_t want;
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: beat expected none, got data %h kind %0d last %0d",
                         $time, data, user, tl);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare("kind", want.kind, user);
            compare("walk_length", want.walk_len, data[lewb_pkg::LEN_W-1:0]);
            compare("erase_event", want.ev, data[lewb_pkg::LEN_W +: lewb_pkg::EV_W]);
            compare("step_index", want.idx,
                    data[lewb_pkg::LEN_W+lewb_pkg::EV_W +: lewb_pkg::IDX_W]);
            compare("step_direction", want.step_dir,
                    data[lewb_pkg::LEN_W+lewb_pkg::EV_W+lewb_pkg::IDX_W +: lewb_pkg::DIR_W]);
            compare("last", want.last, tl);
        endfunction

        // Mostly steps onto a free neighbor so that walks grow long; some
        // steps go straight back, and the rest are random noise.
        function logic [lewb_pkg::DIR_W-1:0] pick_step(int greedy_pct, int back_pct);
            logic [lewb_pkg::DIR_W-1:0] open_dirs [$];
            int                         r;
            r = $urandom_range(0, 99);
            if (r < back_pct && path_len > 0)
                return steps[path_len-1] ^ 2'b01;
            if (r < back_pct + greedy_pct)
            begin
                for (int d = 0; d < 4; d++)
                    if (find_spot(moved(head, lewb_pkg::DIR_W'(d))) < 0)
                        open_dirs.insert(open_dirs.size(), lewb_pkg::DIR_W'(d));
                if (open_dirs.size() > 0)
                    return open_dirs[$urandom_range(0, open_dirs.size() - 1)];
            end
            return lewb_pkg::DIR_W'($urandom_range(0, 3));
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [lewb_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [lewb_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_wr_en = 1'b0;
    logic [lewb_pkg::LEN_W-1:0]       cfg_wr_data = '0;

    walk_scoreboard sb;

    loop_erased_walk_builder_top #(
        .MAX_STEPS (MAX_STEPS),
        .DIMS      (DIMS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls on a pattern of its own: it switches at random
    // intervals between always ready, a light stall and a heavy stall between
    // taken beats.
    int ready_mode = 0;
    int mode_timer = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_timer == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_timer = $urandom_range(20, 100);
            end
            else
            begin
                mode_timer--;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                case (ready_mode)
                    1: stall_left = $urandom_range(0, 1);
                    2: stall_left = $urandom_range(0, 6);
                    default: stall_left = 0;
                endcase
            end
        end
    end

    // Every beat taken on the master side is checked against the oldest
    // expectation. Values are sampled as they stood before this edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Offers one step and holds it until the block takes it. tvalid is left
    // high so that a following step goes out on the very next cycle.
    task automatic send_step(input logic [lewb_pkg::DIR_W-1:0] dir);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(lewb_pkg::S_TDATA_W-lewb_pkg::DIR_W){1'b0}}, dir};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_step(dir);
    endtask

    task automatic hold_off(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops the sender until every expected beat has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // The target is only written with the block idle. The path itself is
    // left alone, so a lowered target is felt at the next step.
    task automatic write_target(input logic [lewb_pkg::LEN_W-1:0] value);
        drain();
        repeat (MAX_STEPS + 8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.target = value;
    endtask

    // Random steps in bursts with random gaps; now and then the sender waits
    // for the block to empty, and some bursts follow each other back to back.
    task automatic run_phase(input int n_items, input int greedy_pct);
        int sent;
        int burst;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                send_step(sb.pick_step(greedy_pct, 8));
                sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                drain();
            else if (r >= 30)
                hold_off($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset target of 64. A step out and straight
        // back returns to the origin on each axis.
        send_step(DIR_XPOS);
        send_step(DIR_XNEG);
        send_step(DIR_YPOS);
        send_step(DIR_YNEG);
        // A unit square closes on the origin and clears the walk.
        send_step(DIR_XPOS);
        send_step(DIR_YPOS);
        send_step(DIR_XNEG);
        send_step(DIR_YNEG);
        // A loop that closes on the first step cuts the path back to one.
        hold_off(3);
        send_step(DIR_XPOS);
        send_step(DIR_XPOS);
        send_step(DIR_YPOS);
        send_step(DIR_XNEG);
        send_step(DIR_YNEG);
        // Grow the path to four steps, then lower the target below it: the
        // next step must flush the whole walk.
        send_step(DIR_XPOS);
        send_step(DIR_XPOS);
        send_step(DIR_YNEG);
        write_target(7'd3);
        send_step(DIR_YNEG);
        // Smallest target, then a target of zero that acts as one.
        write_target(7'd1);
        send_step(DIR_XNEG);
        write_target(7'd0);
        send_step(DIR_YNEG);
        send_step(DIR_YPOS);

        // Random part over several targets, the extremes among them. The
        // path carries over between the long-target phases so that a full
        // walk of the maximum length gets built.
        write_target(7'd127);
        run_phase(60, 85);
        write_target(7'd64);
        run_phase(50, 85);
        write_target(7'd4);
        run_phase(12, 70);
        write_target(7'd1);
        run_phase(8, 50);
        write_target(7'd12);
        run_phase(12, 75);
        write_target(7'd0);
        run_phase(8, 50);
        write_target(7'd65);
        run_phase(10, 85);
        write_target(7'd24);
        run_phase(10, 80);
        write_target(lewb_pkg::LEN_W'($urandom_range(2, 40)));
        run_phase(10, 80);

        drain();
        repeat (MAX_STEPS + 8) @(posedge clk);

        $display("Covered %0d steps giving %0d beats, %0d finished walks (longest %0d).",
                 sb.steps_taken, sb.beats_seen, sb.walks_done, sb.longest);
        $display("Paths were cut back by %0d loop erasures and %0d returns to the origin.",
                 sb.erases, sb.origin_hits);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("Timeout waiting for the block.");
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
